/* rtl/ui_op_frame_parser_macros.svh */
// ----------------------------------------------------------------------------
// UI op frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and idle while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UI_OP_FRAME_PARSER_MACROS_SVH
`define UI_OP_FRAME_PARSER_MACROS_SVH

// Same-cycle implication.
`define UFP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ufp assertion failed");

// Next-cycle implication.
`define UFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ufp assertion failed");

`endif

/* rtl/ufp_pkg.sv */
// ----------------------------------------------------------------------------
// UI op frame parser package
// Types, opcode codes and decode functions shared by the parser files.
// ----------------------------------------------------------------------------
package ufp_pkg;

	localparam int unsigned UFP_LEN_W        = 31;
	localparam int unsigned UFP_WORD_W       = 32;
	localparam int unsigned UFP_RESULT_DEPTH = 4;

	localparam logic [UFP_LEN_W-1:0] UFP_LEN_MAX = {UFP_LEN_W{1'b1}};

	localparam logic [3:0] HDR_BYTES_NONE  = 4'd0;
	localparam logic [3:0] HDR_BYTES_ONE   = 4'd4;
	localparam logic [3:0] HDR_BYTES_LEN16 = 4'd6;
	localparam logic [3:0] HDR_BYTES_TWO   = 4'd8;
	localparam logic [3:0] HDR_BYTES_THREE = 4'd12;

	localparam logic [7:0] OP_LEN16    = 8'd1;
	localparam logic [7:0] OP_WORD1    = 8'd2;
	localparam logic [7:0] OP_WORD3_A  = 8'd3;
	localparam logic [7:0] OP_WORD2_A  = 8'd4;
	localparam logic [7:0] OP_LEN32_A  = 8'd5;
	localparam logic [7:0] OP_LEN32_B  = 8'd6;
	localparam logic [7:0] OP_LEN32_C  = 8'd7;
	localparam logic [7:0] OP_WORD3_B  = 8'd8;
	localparam logic [7:0] OP_BARE     = 8'd9;
	localparam logic [7:0] OP_LEN32_D  = 8'd10;
	localparam logic [7:0] OP_LEN32_E  = 8'd11;
	localparam logic [7:0] OP_WORD2_B  = 8'd12;

	localparam logic KIND_RECORD  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		PH_OPCODE  = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_SKIP    = 2'd3
	} ufp_phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TRUNC   = 2'd1,
		ST_UNKNOWN = 2'd2
	} ufp_status_t;

	typedef enum logic [1:0] {
		LK_NONE  = 2'd0,
		LK_SHORT = 2'd1,
		LK_LONG  = 2'd2
	} ufp_len_kind_t;

	typedef struct packed {
		logic                  item_kind;
		logic [7:0]            opcode;
		logic [UFP_WORD_W-1:0] word_a;
		logic [UFP_WORD_W-1:0] word_b;
		logic [UFP_WORD_W-1:0] word_c;
		logic [UFP_LEN_W-1:0]  payload_length;
		logic [1:0]            status;
		logic [UFP_LEN_W-1:0]  op_count;
		logic [UFP_LEN_W-1:0]  frame_bytes;
		logic                  last;
	} ufp_result_t;

	typedef struct packed {
		logic        rec_valid;
		ufp_result_t rec;
		logic        sum_valid;
		ufp_result_t sum;
	} ufp_push_t;

	function automatic logic ufp_known(input logic [7:0] op);
		logic k;
		case (op)
			OP_LEN16, OP_WORD1, OP_WORD3_A, OP_WORD2_A, OP_LEN32_A, OP_LEN32_B,
			OP_LEN32_C, OP_WORD3_B, OP_BARE, OP_LEN32_D, OP_LEN32_E,
			OP_WORD2_B: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] ufp_hdr_bytes(input logic [7:0] op);
		logic [3:0] n;
		case (op)
			OP_WORD1: n = HDR_BYTES_ONE;
			OP_WORD3_A, OP_WORD3_B: n = HDR_BYTES_THREE;
			OP_WORD2_A, OP_WORD2_B: n = HDR_BYTES_TWO;
			OP_BARE: n = HDR_BYTES_NONE;
			OP_LEN16: n = HDR_BYTES_LEN16;
			OP_LEN32_A, OP_LEN32_B, OP_LEN32_C, OP_LEN32_D, OP_LEN32_E: n = HDR_BYTES_TWO;
			default: n = HDR_BYTES_NONE;
		endcase
		return n;
	endfunction

	function automatic ufp_len_kind_t ufp_len_kind(input logic [7:0] op);
		ufp_len_kind_t k;
		case (op)
			OP_LEN16: k = LK_SHORT;
			OP_LEN32_A, OP_LEN32_B, OP_LEN32_C, OP_LEN32_D, OP_LEN32_E: k = LK_LONG;
			default: k = LK_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [UFP_LEN_W-1:0] ufp_rec_len(input logic [7:0] op,
			input logic [UFP_WORD_W-1:0] w1);
		logic [UFP_LEN_W-1:0] len;
		if (ufp_len_kind(op) == LK_NONE) begin
			len = '0;
		end else if (w1[UFP_WORD_W-1]) begin
			len = UFP_LEN_MAX;
		end else begin
			len = w1[UFP_LEN_W-1:0];
		end
		return len;
	endfunction

	function automatic logic [UFP_LEN_W-1:0] ufp_sat_inc(input logic [UFP_LEN_W-1:0] v);
		return (v == UFP_LEN_MAX) ? v : v + UFP_LEN_W'(1);
	endfunction

endpackage

/* rtl/ufp_byte_if.sv */
// ----------------------------------------------------------------------------
// UI op frame parser byte channel
// One frame byte per transfer, with a flag on the frame's last byte.
// ----------------------------------------------------------------------------
interface ufp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

/* rtl/ufp_result_if.sv */
// ----------------------------------------------------------------------------
// UI op frame parser result channel
// One decoded record or frame summary per transfer.
// ----------------------------------------------------------------------------
interface ufp_result_if;
	logic                           valid;
	logic                           ready;
	logic                           item_kind;
	logic [7:0]                     opcode;
	logic [ufp_pkg::UFP_WORD_W-1:0] word_a;
	logic [ufp_pkg::UFP_WORD_W-1:0] word_b;
	logic [ufp_pkg::UFP_WORD_W-1:0] word_c;
	logic [ufp_pkg::UFP_LEN_W-1:0]  payload_length;
	logic [1:0]                     status;
	logic [ufp_pkg::UFP_LEN_W-1:0]  op_count;
	logic [ufp_pkg::UFP_LEN_W-1:0]  frame_bytes;
	logic                           last;

	modport source (output valid, output item_kind, output opcode, output word_a,
		output word_b, output word_c, output payload_length, output status,
		output op_count, output frame_bytes, output last, input ready);
	modport sink (input valid, input item_kind, input opcode, input word_a,
		input word_b, input word_c, input payload_length, input status,
		input op_count, input frame_bytes, input last, output ready);
endinterface

/* rtl/ui_op_frame_parser.sv */
// ----------------------------------------------------------------------------
// UI op frame parser
// Decodes little-endian op records from a byte stream and reports each frame.
//
//   Channel      Direction  Transfer
//   byte_in      in         one frame byte and its frame_end flag
//   result_out   out        one decoded record or one frame summary
//   cfg_we       in         record_enable write, data on cfg_wdata
//
// One byte is taken per cycle while the queue has room. A byte's results
// pass the decode stage register and the result queue before result_out.
// A byte that both completes a record and ends the frame gives two results,
// which the result queue drains one per cycle while result_out is ready.
// The decode stage waits while the queue lacks room for two results.
// Reset clears the record state, the queue and sets record_enable.
// ----------------------------------------------------------------------------
module ui_op_frame_parser #(
	parameter int unsigned RESULT_DEPTH = ufp_pkg::UFP_RESULT_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	ufp_byte_if.sink     byte_in,
	ufp_result_if.source result_out
);
	import ufp_pkg::*;

	logic      rec_en_q;
	logic      room;
	ufp_push_t push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_en_q <= 1'b1;
		end else if (cfg_we) begin
			rec_en_q <= cfg_wdata;
		end
	end

	ufp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec_en  (rec_en_q),
		.room    (room),
		.byte_in (byte_in),
		.push    (push)
	);

	ufp_out_fifo #(
		.DEPTH (RESULT_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.result_out (result_out)
	);

endmodule

/* rtl/ufp_parse.sv */
// ----------------------------------------------------------------------------
// UI op frame parser decode stage
// Registers each byte, advances the record state and forms the results of it.
// ----------------------------------------------------------------------------
module ufp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_en,
	input  logic              room,
	ufp_byte_if.sink          byte_in,
	output ufp_pkg::ufp_push_t push
);
	import ufp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       advance;

	ufp_phase_t                  phase_q, phase_n;
	logic [7:0]                  op_q, op_n;
	logic [3:0]                  idx_q, idx_n, idx_inc;
	logic [2:0][UFP_WORD_W-1:0]  words_q, words_n, words_ins;
	logic [UFP_LEN_W-1:0]        left_q, left_n, left_dec;
	logic [UFP_LEN_W-1:0]        ops_q, ops_n;
	logic [UFP_LEN_W-1:0]        bytes_q, bytes_n;
	logic                        err_q, err_n;
	logic                        finish;
	logic [UFP_LEN_W-1:0]        hdr_len;
	ufp_result_t                 rec;
	ufp_result_t                 sum;

	assign advance       = valid_s1 && room;
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.data_byte;
			end_s1  <= byte_in.frame_end;
		end
	end

	always_comb begin
		words_ins = words_q;
		for (int w = 0; w < 3; w++) begin
			for (int k = 0; k < 4; k++) begin
				if (idx_q[3:2] == 2'(w) && idx_q[1:0] == 2'(k)) begin
					words_ins[w][8*k +: 8] = words_q[w][8*k +: 8] | byte_s1;
				end
			end
		end
	end

	assign idx_inc  = idx_q + 4'd1;
	assign hdr_len  = ufp_rec_len(op_q, words_ins[1]);
	assign left_dec = (left_q != '0) ? left_q - UFP_LEN_W'(1) : left_q;

	always_comb begin
		phase_n = phase_q;
		op_n    = op_q;
		idx_n   = idx_q;
		words_n = words_q;
		left_n  = left_q;
		ops_n   = ops_q;
		bytes_n = ufp_sat_inc(bytes_q);
		err_n   = err_q;
		finish  = 1'b0;
		case (phase_q)
			PH_OPCODE: begin
				op_n = byte_s1;
				if (!ufp_known(byte_s1)) begin
					err_n   = 1'b1;
					phase_n = PH_SKIP;
				end else begin
					idx_n   = '0;
					words_n = '0;
					if (ufp_hdr_bytes(byte_s1) == HDR_BYTES_NONE) begin
						finish = 1'b1;
					end else begin
						phase_n = PH_HEADER;
					end
				end
			end
			PH_HEADER: begin
				words_n = words_ins;
				idx_n   = idx_inc;
				if (idx_inc == ufp_hdr_bytes(op_q)) begin
					if (hdr_len == '0) begin
						finish = 1'b1;
					end else begin
						left_n  = hdr_len;
						phase_n = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				left_n = left_dec;
				if (left_dec == '0) begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (finish) begin
			ops_n   = ufp_sat_inc(ops_q);
			phase_n = PH_OPCODE;
		end
	end

	always_comb begin
		rec                = '0;
		rec.item_kind      = KIND_RECORD;
		rec.opcode         = op_n;
		rec.word_a         = words_n[0];
		rec.payload_length = ufp_rec_len(op_n, words_n[1]);
		if (ufp_len_kind(op_n) == LK_NONE) begin
			rec.word_b = words_n[1];
			rec.word_c = words_n[2];
		end

		sum             = '0;
		sum.item_kind   = KIND_SUMMARY;
		sum.op_count    = ops_n;
		sum.frame_bytes = bytes_n;
		sum.last        = 1'b1;
		if (err_n) begin
			sum.status = ST_UNKNOWN;
			sum.opcode = op_n;
		end else if (phase_n != PH_OPCODE) begin
			sum.status = ST_TRUNC;
			sum.opcode = op_n;
		end else begin
			sum.status = ST_OK;
		end
	end

	always_comb begin
		push.rec_valid = advance && finish && rec_en;
		push.rec       = rec;
		push.sum_valid = advance && end_s1;
		push.sum       = sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPCODE;
			op_q    <= '0;
			idx_q   <= '0;
			words_q <= '0;
			left_q  <= '0;
			ops_q   <= '0;
			bytes_q <= '0;
			err_q   <= 1'b0;
		end else if (advance) begin
			if (end_s1) begin
				phase_q <= PH_OPCODE;
				op_q    <= '0;
				idx_q   <= '0;
				words_q <= '0;
				left_q  <= '0;
				ops_q   <= '0;
				bytes_q <= '0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				op_q    <= op_n;
				idx_q   <= idx_n;
				words_q <= words_n;
				left_q  <= left_n;
				ops_q   <= ops_n;
				bytes_q <= bytes_n;
				err_q   <= err_n;
			end
		end
	end

endmodule

/* rtl/ufp_out_fifo.sv */
// ----------------------------------------------------------------------------
// UI op frame parser result queue
// Registered entries taking up to two results a cycle, giving one when ready.
// ----------------------------------------------------------------------------
module ufp_out_fifo #(
	parameter int unsigned DEPTH = ufp_pkg::UFP_RESULT_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ufp_pkg::ufp_push_t push,
	output logic               room,
	ufp_result_if.source       result_out
);
	import ufp_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ufp_result_t      entries_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] wr_nxt;
	logic [1:0]       n_push;
	logic             pop;
	ufp_result_t      first;
	ufp_result_t      head;

	assign n_push = {1'b0, push.rec_valid} + {1'b0, push.sum_valid};
	assign first  = push.rec_valid ? push.rec : push.sum;
	assign wr_nxt = wr_q + PTR_W'(1);
	assign pop    = result_out.valid && result_out.ready;
	assign room   = cnt_q <= CNT_W'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.rec_valid || push.sum_valid) begin
			entries_q[wr_q] <= first;
		end
		if (push.rec_valid && push.sum_valid) begin
			entries_q[wr_nxt] <= push.sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	assign head = entries_q[rd_q];

	assign result_out.valid          = cnt_q != '0;
	assign result_out.item_kind      = head.item_kind;
	assign result_out.opcode         = head.opcode;
	assign result_out.word_a         = head.word_a;
	assign result_out.word_b         = head.word_b;
	assign result_out.word_c         = head.word_c;
	assign result_out.payload_length = head.payload_length;
	assign result_out.status         = head.status;
	assign result_out.op_count       = head.op_count;
	assign result_out.frame_bytes    = head.frame_bytes;
	assign result_out.last           = head.last;

endmodule

/* rtl/ufp_checker.sv */
// ----------------------------------------------------------------------------
// UI op frame parser port checker
// Checks the result channel of the parser as seen at its ports.
// ----------------------------------------------------------------------------
`include "ui_op_frame_parser_macros.svh"

module ufp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           item_kind,
	input logic [7:0]                     opcode,
	input logic [ufp_pkg::UFP_WORD_W-1:0] word_a,
	input logic [ufp_pkg::UFP_WORD_W-1:0] word_b,
	input logic [ufp_pkg::UFP_WORD_W-1:0] word_c,
	input logic [ufp_pkg::UFP_LEN_W-1:0]  payload_length,
	input logic [1:0]                     status,
	input logic [ufp_pkg::UFP_LEN_W-1:0]  op_count,
	input logic [ufp_pkg::UFP_LEN_W-1:0]  frame_bytes,
	input logic                           last
);
	import ufp_pkg::*;

	ufp_result_t head_bits;
	logic        out_stall;
	logic        is_record;
	logic        is_summary;
	logic        record_zeros;
	logic        summary_shape;
	logic        status_ok;

	assign head_bits = {item_kind, opcode, word_a, word_b, word_c, payload_length, status,
		op_count, frame_bytes, last};
	assign out_stall  = out_valid && !out_ready;
	assign is_record  = out_valid && item_kind == KIND_RECORD;
	assign is_summary = out_valid && item_kind == KIND_SUMMARY;

	assign record_zeros = status == ST_OK && op_count == '0 && frame_bytes == '0 && !last;
	assign summary_shape = last && word_a == '0 && word_b == '0 && word_c == '0 &&
		payload_length == '0 && frame_bytes != '0 && op_count <= frame_bytes;
	assign status_ok = (status == ST_OK && opcode == '0) || status == ST_TRUNC ||
		status == ST_UNKNOWN;

	`UFP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(head_bits))

	`UFP_ASSERT_IMPL(a_record_clean, is_record, record_zeros)

	`UFP_ASSERT_IMPL(a_summary_shape, is_summary, summary_shape)

	`UFP_ASSERT_IMPL(a_summary_status, is_summary, status_ok)

endmodule

bind ui_op_frame_parser ufp_checker u_ufp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result_out.valid),
	.out_ready      (result_out.ready),
	.item_kind      (result_out.item_kind),
	.opcode         (result_out.opcode),
	.word_a         (result_out.word_a),
	.word_b         (result_out.word_b),
	.word_c         (result_out.word_c),
	.payload_length (result_out.payload_length),
	.status         (result_out.status),
	.op_count       (result_out.op_count),
	.frame_bytes    (result_out.frame_bytes),
	.last           (result_out.last)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UI op frame parser testbench
// Streams op frames into the parser one byte per transfer and checks every
// decoded record and frame summary against a predictor kept in the
// testbench. A few directed frames hit the corner cases; the rest are random
// frames, mostly well formed, with truncated, unknown opcode and noise frames
// mixed in. Both channels idle at random, and record output is turned off
// and on again between phases.
// ----------------------------------------------------------------------------
module tb;
	import ufp_pkg::*;

	localparam int TIMEOUT_CYCLES = 300000;
	localparam int SETTLE_CYCLES  = 10;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ufp_byte_if   byte_ch ();
	ufp_result_if res_ch ();

	ui_op_frame_parser u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.byte_in    (byte_ch),
		.result_out (res_ch)
	);

	always #5 clk = ~clk;

	// Parser state as predicted by the testbench.
	logic             rec_enable;
	ufp_phase_t       parse_phase;
	logic [7:0]       parse_op;
	logic [3:0]       hdr_pos;
	logic [31:0]      hdr_word [3];
	logic [30:0]      skip_left;
	logic [30:0]      frame_ops;
	logic [30:0]      frame_len;
	logic             saw_unknown;

	ufp_result_t pending_results [$];
	logic [7:0]  frame_buf [$];

	logic steady;
	int   mismatches;
	int   bytes_sent;
	int   frames_sent;
	int   records_seen;
	int   summaries_seen;
	int   status_seen [3];

	ufp_result_t want_r;
	ufp_result_t got_r;
	string       diff;

	function automatic int hdr_len(input logic [7:0] op);
		int n;
		case (op)
			OP_WORD1: n = int'(HDR_BYTES_ONE);
			OP_WORD3_A, OP_WORD3_B: n = int'(HDR_BYTES_THREE);
			OP_WORD2_A, OP_WORD2_B: n = int'(HDR_BYTES_TWO);
			OP_BARE: n = int'(HDR_BYTES_NONE);
			OP_LEN16: n = int'(HDR_BYTES_LEN16);
			OP_LEN32_A, OP_LEN32_B, OP_LEN32_C, OP_LEN32_D, OP_LEN32_E:
				n = int'(HDR_BYTES_TWO);
			default: n = -1;
		endcase
		return n;
	endfunction

	function automatic logic has_length(input logic [7:0] op);
		return op == OP_LEN16 || op == OP_LEN32_A || op == OP_LEN32_B ||
			op == OP_LEN32_C || op == OP_LEN32_D || op == OP_LEN32_E;
	endfunction

	function automatic logic [30:0] bump(input logic [30:0] v);
		return (&v) ? v : v + 31'd1;
	endfunction

	function automatic logic [30:0] skip_count();
		logic [30:0] n;
		if (!has_length(parse_op))
			n = '0;
		else if (hdr_word[1][31])
			n = '1;
		else
			n = hdr_word[1][30:0];
		return n;
	endfunction

	function automatic void clear_parse_state();
		parse_phase = PH_OPCODE;
		parse_op    = '0;
		hdr_pos     = '0;
		hdr_word    = '{default: '0};
		skip_left   = '0;
		frame_ops   = '0;
		frame_len   = '0;
		saw_unknown = 1'b0;
	endfunction

	function automatic void complete_record();
		ufp_result_t r;
		frame_ops   = bump(frame_ops);
		parse_phase = PH_OPCODE;
		if (rec_enable) begin
			r                = '0;
			r.item_kind      = KIND_RECORD;
			r.opcode         = parse_op;
			r.word_a         = hdr_word[0];
			r.word_b         = has_length(parse_op) ? '0 : hdr_word[1];
			r.word_c         = has_length(parse_op) ? '0 : hdr_word[2];
			r.payload_length = skip_count();
			pending_results.insert(pending_results.size(), r);
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic fe);
		int          hb;
		logic [30:0] n;
		ufp_result_t r;
		ufp_status_t st;
		frame_len = bump(frame_len);
		case (parse_phase)
			PH_OPCODE: begin
				parse_op = b;
				hb = hdr_len(b);
				if (hb < 0) begin
					saw_unknown = 1'b1;
					parse_phase = PH_SKIP;
				end else begin
					hdr_pos  = '0;
					hdr_word = '{default: '0};
					if (hb == 0)
						complete_record();
					else
						parse_phase = PH_HEADER;
				end
			end
			PH_HEADER: begin
				hb = hdr_len(parse_op);
				if (hdr_pos < 4'd12)
					hdr_word[hdr_pos[3:2]] |= 32'(b) << (8 * hdr_pos[1:0]);
				hdr_pos = hdr_pos + 4'd1;
				if (int'(hdr_pos) >= hb) begin
					n = skip_count();
					if (n == '0) begin
						complete_record();
					end else begin
						skip_left   = n;
						parse_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (skip_left != '0)
					skip_left = skip_left - 31'd1;
				if (skip_left == '0)
					complete_record();
			end
			default: ;
		endcase
		if (fe) begin
			if (saw_unknown)
				st = ST_UNKNOWN;
			else if (parse_phase != PH_OPCODE)
				st = ST_TRUNC;
			else
				st = ST_OK;
			r             = '0;
			r.item_kind   = KIND_SUMMARY;
			r.opcode      = (st == ST_OK) ? 8'h00 : parse_op;
			r.status      = st;
			r.op_count    = frame_ops;
			r.frame_bytes = frame_len;
			r.last        = 1'b1;
			pending_results.insert(pending_results.size(), r);
			clear_parse_state();
		end
	endfunction

	function automatic string diff_fields(input ufp_result_t e, input ufp_result_t g);
		string s;
		s = "";
		if (e.item_kind !== g.item_kind)
			s = {s, $sformatf(" item_kind %0h/%0h", e.item_kind, g.item_kind)};
		if (e.opcode !== g.opcode)
			s = {s, $sformatf(" opcode %0h/%0h", e.opcode, g.opcode)};
		if (e.word_a !== g.word_a)
			s = {s, $sformatf(" word_a %0h/%0h", e.word_a, g.word_a)};
		if (e.word_b !== g.word_b)
			s = {s, $sformatf(" word_b %0h/%0h", e.word_b, g.word_b)};
		if (e.word_c !== g.word_c)
			s = {s, $sformatf(" word_c %0h/%0h", e.word_c, g.word_c)};
		if (e.payload_length !== g.payload_length)
			s = {s, $sformatf(" payload_length %0h/%0h", e.payload_length,
				g.payload_length)};
		if (e.status !== g.status)
			s = {s, $sformatf(" status %0h/%0h", e.status, g.status)};
		if (e.op_count !== g.op_count)
			s = {s, $sformatf(" op_count %0h/%0h", e.op_count, g.op_count)};
		if (e.frame_bytes !== g.frame_bytes)
			s = {s, $sformatf(" frame_bytes %0h/%0h", e.frame_bytes, g.frame_bytes)};
		if (e.last !== g.last)
			s = {s, $sformatf(" last %0h/%0h", e.last, g.last)};
		return s;
	endfunction

	always @(posedge clk) begin
		res_ch.ready <= steady || ($urandom_range(99) >= 26);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got_r                = '0;
			got_r.item_kind      = res_ch.item_kind;
			got_r.opcode         = res_ch.opcode;
			got_r.word_a         = res_ch.word_a;
			got_r.word_b         = res_ch.word_b;
			got_r.word_c         = res_ch.word_c;
			got_r.payload_length = res_ch.payload_length;
			got_r.status         = res_ch.status;
			got_r.op_count       = res_ch.op_count;
			got_r.frame_bytes    = res_ch.frame_bytes;
			got_r.last           = res_ch.last;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result at %0t: kind %0h opcode %0h status %0h",
						$realtime, got_r.item_kind, got_r.opcode, got_r.status);
			end else begin
				want_r = pending_results.pop_front();
				diff = diff_fields(want_r, got_r);
				if (diff != "") begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at %0t (expected/actual):%s", $realtime, diff);
				end else if (got_r.item_kind == KIND_SUMMARY) begin
					summaries_seen++;
					status_seen[got_r.status]++;
				end else begin
					records_seen++;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fe);
		while (!steady && $urandom_range(99) < 26) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.frame_end <= fe;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		decode_byte(b, fe);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	task automatic drain();
		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_record_enable(input logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		rec_enable = v;
	endtask

	function automatic void add_byte(input logic [7:0] b);
		frame_buf.insert(frame_buf.size(), b);
	endfunction

	function automatic void push_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			add_byte(w[8*k +: 8]);
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		case ($urandom_range(0, 3))
			0: w = '0;
			1: w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] pick_known_op();
		logic [7:0] op;
		case ($urandom_range(0, 11))
			0: op = OP_LEN16;
			1: op = OP_WORD1;
			2: op = OP_WORD3_A;
			3: op = OP_WORD2_A;
			4: op = OP_LEN32_A;
			5: op = OP_LEN32_B;
			6: op = OP_LEN32_C;
			7: op = OP_WORD3_B;
			8: op = OP_BARE;
			9: op = OP_LEN32_D;
			10: op = OP_LEN32_E;
			default: op = OP_WORD2_B;
		endcase
		return op;
	endfunction

	function automatic logic [7:0] pick_length_op();
		logic [7:0] op;
		case ($urandom_range(0, 5))
			0: op = OP_LEN16;
			1: op = OP_LEN32_A;
			2: op = OP_LEN32_B;
			3: op = OP_LEN32_C;
			4: op = OP_LEN32_D;
			default: op = OP_LEN32_E;
		endcase
		return op;
	endfunction

	function automatic void add_record(input logic [7:0] op, input logic [31:0] len,
			input int payload_cap);
		logic [31:0] plen;
		int          n;
		add_byte(op);
		plen = '0;
		if (op == OP_LEN16) begin
			push_word(pick_word());
			add_byte(len[7:0]);
			add_byte(len[15:8]);
			plen = {16'h0000, len[15:0]};
		end else if (has_length(op)) begin
			push_word(pick_word());
			push_word(len);
			plen = len;
		end else begin
			for (int k = 0; k < hdr_len(op); k += 4)
				push_word(pick_word());
		end
		n = (plen > 32'(payload_cap)) ? payload_cap : int'(plen);
		repeat (n) add_byte(8'($urandom));
	endfunction

	function automatic void build_frame();
		int          shape;
		int          keep;
		logic [7:0]  op;
		logic [31:0] len;
		frame_buf.delete();
		shape = $urandom_range(0, 99);
		if (shape < 10) begin
			repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			add_record(pick_known_op(), len, 1000);
		end
		if (shape < 20) begin
			do
				op = 8'($urandom);
			while (hdr_len(op) >= 0);
			add_byte(op);
			repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
		end else if (shape < 30) begin
			op = pick_length_op();
			len = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000) : $urandom_range(100, 70000);
			add_record(op, len, $urandom_range(0, 5));
		end else if (shape < 40) begin
			keep = $urandom_range(1, frame_buf.size());
			while (frame_buf.size() > keep)
				void'(frame_buf.pop_back());
		end
	endfunction

	task automatic run_random_frames(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			build_frame();
			send_frame();
		end
		drain();
	endtask

	task automatic test_corner_frames();
		frame_buf.delete();
		add_byte(OP_BARE);
		send_frame();
		frame_buf.delete();
		add_byte(8'hFF);
		send_frame();
		frame_buf.delete();
		add_byte(OP_WORD1);
		push_word(32'hFFFF_FFFF);
		add_byte(8'h00);
		add_byte(8'h55);
		send_frame();
		frame_buf.delete();
		add_byte(OP_LEN32_A);
		push_word(32'h0000_0000);
		push_word(32'hFFFF_FFFF);
		send_frame();
		frame_buf.delete();
		add_byte(OP_LEN16);
		push_word(32'h8000_0001);
		add_byte(8'h00);
		add_byte(8'h00);
		send_frame();
		frame_buf.delete();
		add_byte(OP_WORD3_A);
		add_byte(8'hA5);
		add_byte(8'h5A);
		send_frame();
		drain();
	endtask

	task automatic test_summaries_only();
		set_record_enable(1'b0);
		run_random_frames(200);
	endtask

	task automatic test_random_frames();
		set_record_enable(1'b1);
		run_random_frames(800);
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		run_random_frames(300);
		steady = 1'b0;
	endtask

	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.frame_end = 1'b0;
		res_ch.ready      = 1'b0;
		steady            = 1'b0;
		mismatches        = 0;
		bytes_sent        = 0;
		frames_sent       = 0;
		records_seen      = 0;
		summaries_seen    = 0;
		status_seen       = '{default: 0};
		rec_enable        = 1'b1;
		clear_parse_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_frames();
		test_summaries_only();
		test_random_frames();
		test_back_to_back();

		$display("Sent %0d frames in %0d byte transfers; checked %0d records and %0d summaries.",
			frames_sent, bytes_sent, records_seen, summaries_seen);
		$display("Frame status mix: %0d ok, %0d truncated, %0d unknown opcode.",
			status_seen[0], status_seen[1], status_seen[2]);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* ui_op_frame_parser.f */
+incdir+rtl
rtl/ufp_pkg.sv
rtl/ufp_byte_if.sv
rtl/ufp_result_if.sv
rtl/ufp_parse.sv
rtl/ufp_out_fifo.sv
rtl/ui_op_frame_parser.sv
rtl/ufp_checker.sv
tb/tb.sv
